// ===== hdl/yuyv_pkg.sv =====
// ----------------------------------------------------------------------------
// yuyv_pkg
// shared constants, widths and types for the yuyv to rgb888 converter
// ----------------------------------------------------------------------------
package yuyv_pkg;

    localparam int unsigned SAMPLE_W  = 8;
    localparam int unsigned PROD_W    = 20;
    localparam int unsigned SUM_W     = 21;
    localparam int unsigned FRAC_BITS = 10;
    localparam int unsigned NUM_LANES = 2;

    localparam logic signed [11:0] COEF_Y    = 12'sd1192;
    localparam logic signed [12:0] COEF_CB_B = 13'sd2066;
    localparam logic signed [11:0] COEF_CR_G = 12'sd833;
    localparam logic signed [11:0] COEF_CB_G = 12'sd403;
    localparam logic signed [11:0] COEF_CR_R = 12'sd1634;

    localparam logic signed [9:0] LUMA_OFF   = 10'sd16;
    localparam logic signed [9:0] CHROMA_OFF = 10'sd128;

    localparam logic signed [SUM_W-1:0] LIMIT_SUM = SUM_W'(250 * 1024);
    localparam logic [SAMPLE_W-1:0]     CHAN_MAX  = 8'd255;

    // registered chroma products shared by both lanes
    typedef struct packed {
        logic signed [PROD_W-1:0] cr_r;
        logic signed [PROD_W-1:0] cr_g;
        logic signed [PROD_W-1:0] cb_g;
        logic signed [PROD_W-1:0] cb_b;
    } chroma_terms_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] blue;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] red;
    } rgb_t;

    // pipeline stage enables
    typedef struct packed {
        logic s1;
        logic s2;
    } stage_en_t;

    function automatic logic [SAMPLE_W-1:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
        logic [SAMPLE_W-1:0] res;
        if (sum < 0)
        begin
            res = '0;
        end
        else if (sum > LIMIT_SUM)
        begin
            res = CHAN_MAX;
        end
        else
        begin
            res = sum[FRAC_BITS +: SAMPLE_W];
        end
        return res;
    endfunction

endpackage

// ===== hdl/yuyv_chroma.sv =====
// ----------------------------------------------------------------------------
// yuyv_chroma
// shared chroma products for one macropixel, registered once for both lanes
// ----------------------------------------------------------------------------
module yuyv_chroma
    import yuyv_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [SAMPLE_W-1:0] chroma_blue,
    input  logic [SAMPLE_W-1:0] chroma_red,
    output chroma_terms_t       terms
);

    chroma_terms_t       terms_reg;
    chroma_terms_t       terms_next;
    logic signed [9:0]   db;
    logic signed [9:0]   dr;
    logic signed [22:0]  p_cr_r;
    logic signed [22:0]  p_cr_g;
    logic signed [22:0]  p_cb_g;
    logic signed [22:0]  p_cb_b;

    always_comb
    begin
        db     = $signed({2'b00, chroma_blue}) - CHROMA_OFF;
        dr     = $signed({2'b00, chroma_red}) - CHROMA_OFF;
        p_cr_r = 23'(COEF_CR_R * dr);
        p_cr_g = 23'(COEF_CR_G * dr);
        p_cb_g = 23'(COEF_CB_G * db);
        p_cb_b = 23'(COEF_CB_B * db);
        terms_next.cr_r = p_cr_r[PROD_W-1:0];
        terms_next.cr_g = p_cr_g[PROD_W-1:0];
        terms_next.cb_g = p_cb_g[PROD_W-1:0];
        terms_next.cb_b = p_cb_b[PROD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

endmodule

// ===== hdl/yuyv_lane.sv =====
// ----------------------------------------------------------------------------
// yuyv_lane
// one pixel lane: luma product, channel sums and clamping to rgb888
// ----------------------------------------------------------------------------
module yuyv_lane
    import yuyv_pkg::*;
(
    input  logic                clk,
    input  stage_en_t           en,
    input  logic [SAMPLE_W-1:0] luma,
    input  chroma_terms_t       terms,
    output rgb_t                pixel
);

    logic signed [PROD_W-1:0] ly_reg;
    logic signed [PROD_W-1:0] ly_next;
    logic signed [9:0]        dy;
    logic signed [21:0]       ly_full;
    logic signed [SUM_W-1:0]  sum_r;
    logic signed [SUM_W-1:0]  sum_g;
    logic signed [SUM_W-1:0]  sum_b;
    rgb_t                     pixel_reg;
    rgb_t                     pixel_next;

    always_comb
    begin
        dy      = $signed({2'b00, luma}) - LUMA_OFF;
        ly_full = 22'(COEF_Y * dy);
        ly_next = ly_full[PROD_W-1:0];
    end

    always_comb
    begin
        sum_r = SUM_W'(ly_reg) + SUM_W'(terms.cr_r);
        sum_g = SUM_W'(ly_reg) - SUM_W'(terms.cr_g) - SUM_W'(terms.cb_g);
        sum_b = SUM_W'(ly_reg) + SUM_W'(terms.cb_b);
        pixel_next.red   = clamp_channel(sum_r);
        pixel_next.green = clamp_channel(sum_g);
        pixel_next.blue  = clamp_channel(sum_b);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            ly_reg <= ly_next;
        end
        if (en.s2)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule

// ===== hdl/yuyv_to_rgb_converter_top.sv =====
// ----------------------------------------------------------------------------
// yuyv_to_rgb_converter_top
// yuyv macropixel to two rgb888 pixels, bt.601 limited range, two lanes
//
// channel   dir  tdata fields (lsb first)
// s_axis    in   luma_first, chroma_blue, luma_second, chroma_red (32 bits)
// m_axis    out  red/green/blue_first, red/green/blue_second (48 bits)
//
// one transaction per cycle sustained while m_axis is ready; each passes
// through the product stage and then the sum/clamp stage to the output
// two items can be held when m_axis stalls, s_axis keeps accepting until full
// rst_n clears only the stage valid flags
// ----------------------------------------------------------------------------
module yuyv_to_rgb_converter_top
    import yuyv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // luma_first, chroma_blue, luma_second, chroma_red
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // red_first, green_first, blue_first,
                                       // red_second, green_second, blue_second
);

    logic          v1_reg;
    logic          v1_next;
    logic          v2_reg;
    logic          v2_next;
    stage_en_t     en;
    logic          accept;
    chroma_terms_t terms;
    rgb_t          pixels [NUM_LANES];
    logic [SAMPLE_W-1:0] lumas [NUM_LANES];

    always_comb
    begin
        en.s2   = !v2_reg || m_axis_tready;
        en.s1   = !v1_reg || en.s2;
        accept  = s_axis_tvalid && en.s1;
        v1_next = en.s1 ? s_axis_tvalid : v1_reg;
        v2_next = en.s2 ? v1_reg : v2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    assign lumas[0] = s_axis_tdata[7:0];
    assign lumas[1] = s_axis_tdata[23:16];

    yuyv_chroma u_chroma (
        .clk         (clk),
        .en          (en.s1),
        .chroma_blue (s_axis_tdata[15:8]),
        .chroma_red  (s_axis_tdata[31:24]),
        .terms       (terms)
    );

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        yuyv_lane u_lane (
            .clk   (clk),
            .en    (en),
            .luma  (lumas[i]),
            .terms (terms),
            .pixel (pixels[i])
        );
    end

    // merge lane pixels into the output beat
    assign m_axis_tdata  = {pixels[1].blue, pixels[1].green, pixels[1].red,
                            pixels[0].blue, pixels[0].green, pixels[0].red};
    assign m_axis_tvalid = v2_reg;
    assign s_axis_tready = en.s1;

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> v1_reg)
        else $error("accepted transaction not held in product stage");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v2_reg |-> s_axis_tready)
        else $error("not ready although output stage empty");

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !en.s2 |=> v1_reg && v2_reg)
        else $error("item dropped while output stalled");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && en.s2 |=> v2_reg)
        else $error("product stage item did not reach output stage");

endmodule

// ===== sim/tb_yuyv_to_rgb_converter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_yuyv_to_rgb_converter_top
// self-checking bench for the yuyv to rgb888 converter
//
// drives yuyv macropixels on s_axis and predicts both rgb888 pixels per
// transaction with a local fixed-point model. every m_axis transaction is
// checked field by field against the oldest prediction. directed cases hit
// the clamp edges and the saturation band around 250, then a random stream
// runs with random idling on both sides, and a long output hold-off fills
// the pipeline so that s_axis has to stall.
// ----------------------------------------------------------------------------
module tb_yuyv_to_rgb_converter_top
    import yuyv_pkg::*;
();

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int SAT_SUM      = 250 * 1024;
    localparam int K_LUMA       = 1192;
    localparam int K_CB_BLUE    = 2066;
    localparam int K_CR_GREEN   = 833;
    localparam int K_CB_GREEN   = 403;
    localparam int K_CR_RED     = 1634;
    localparam int LUMA_BASE    = 16;
    localparam int CHROMA_BASE  = 128;

    typedef enum int {CH_RED, CH_GREEN, CH_BLUE} chan_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    logic [47:0] rgb_pairs_due[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          rx_wait = 0;
    bit          tx_idle_en = 1'b0;
    bit          rx_idle_en = 1'b0;
    bit          hold_req = 1'b0;
    string       chan_names[6] = '{"red_first", "green_first", "blue_first",
                                   "red_second", "green_second", "blue_second"};

    yuyv_to_rgb_converter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    function automatic int chan_sum(input chan_t ch, input int luma, input int cb, input int cr);
        int base;
        base = K_LUMA * (luma - LUMA_BASE);
        case (ch)
            CH_RED:   return base + K_CR_RED * (cr - CHROMA_BASE);
            CH_GREEN: return base - K_CR_GREEN * (cr - CHROMA_BASE)
                             - K_CB_GREEN * (cb - CHROMA_BASE);
            default:  return base + K_CB_BLUE * (cb - CHROMA_BASE);
        endcase
    endfunction

    function automatic logic [7:0] saturate_chan(input int acc);
        if (acc < 0)
        begin
            return 8'd0;
        end
        else if (acc > SAT_SUM)
        begin
            return 8'd255;
        end
        else
        begin
            return acc[17:10];
        end
    endfunction

    function automatic rgb_t convert_pel(input logic [7:0] luma, input logic [7:0] cb,
                                         input logic [7:0] cr);
        rgb_t pel;
        pel.red   = saturate_chan(chan_sum(CH_RED, int'(luma), int'(cb), int'(cr)));
        pel.green = saturate_chan(chan_sum(CH_GREEN, int'(luma), int'(cb), int'(cr)));
        pel.blue  = saturate_chan(chan_sum(CH_BLUE, int'(luma), int'(cb), int'(cr)));
        return pel;
    endfunction

    function automatic logic [47:0] convert_macropixel(input logic [31:0] word);
        rgb_t first_pel;
        rgb_t second_pel;
        first_pel  = convert_pel(word[7:0], word[15:8], word[31:24]);
        second_pel = convert_pel(word[23:16], word[15:8], word[31:24]);
        return {second_pel, first_pel};
    endfunction

    function automatic logic [31:0] pack_yuyv(input logic [7:0] luma0, input logic [7:0] cb,
                                              input logic [7:0] luma1, input logic [7:0] cr);
        return {cr, luma1, cb, luma0};
    endfunction

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hff;
            2, 3:    return 8'($urandom_range(16, 240));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_macropixel(input logic [31:0] word);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        if (tx_idle_en && $urandom_range(0, 99) < 30)
        begin
            gap = idle_len();
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom();
            repeat (gap) @(posedge clk);
        end
    endtask

    // look for a luma/chroma pair whose channel sum falls in [lo, hi]
    task automatic send_near_limit(input chan_t ch, input int lo, input int hi);
        int  acc;
        int  cb;
        int  cr;
        bit  hit;
        logic [7:0] luma;
        logic [7:0] chroma;
        hit    = 1'b0;
        luma   = '0;
        chroma = '0;
        for (int y = 0; y < 256 && !hit; y++)
        begin
            for (int c = 0; c < 256 && !hit; c++)
            begin
                cb  = (ch == CH_BLUE) ? c : CHROMA_BASE;
                cr  = (ch == CH_BLUE) ? CHROMA_BASE : c;
                acc = chan_sum(ch, y, cb, cr);
                if (acc >= lo && acc <= hi)
                begin
                    hit    = 1'b1;
                    luma   = 8'(y);
                    chroma = 8'(c);
                end
            end
        end
        if (hit)
        begin
            if (ch == CH_BLUE)
            begin
                send_macropixel(pack_yuyv(luma, chroma, luma, 8'(CHROMA_BASE)));
            end
            else
            begin
                send_macropixel(pack_yuyv(luma, 8'(CHROMA_BASE), luma, chroma));
            end
        end
    endtask

    task automatic run_directed_cases();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_macropixel(pack_yuyv(8'h00, 8'h00, 8'h00, 8'h00));
        send_macropixel(pack_yuyv(8'hff, 8'hff, 8'hff, 8'hff));
        send_macropixel(pack_yuyv(8'd16, 8'd128, 8'd16, 8'd128));
        send_macropixel(pack_yuyv(8'd235, 8'd128, 8'd235, 8'd128));
        send_macropixel(pack_yuyv(8'hff, 8'd128, 8'h00, 8'd128));
        send_macropixel(pack_yuyv(8'h00, 8'hff, 8'hff, 8'h00));
        send_macropixel(pack_yuyv(8'hff, 8'h00, 8'h00, 8'hff));
        send_macropixel(pack_yuyv(8'h80, 8'h00, 8'h80, 8'hff));
        send_macropixel(pack_yuyv(8'h55, 8'haa, 8'haa, 8'h55));
        // exact limit, saturation band above it, and just below it
        for (int k = CH_RED; k <= CH_BLUE; k++)
        begin
            send_near_limit(chan_t'(k), SAT_SUM, SAT_SUM);
            send_near_limit(chan_t'(k), SAT_SUM + 1, SAT_SUM + 1023);
            send_near_limit(chan_t'(k), SAT_SUM - 1023, SAT_SUM - 1);
        end
    endtask

    task automatic run_random_stream();
        for (int chunk = 0; chunk < 10; chunk++)
        begin
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            repeat (50)
            begin
                send_macropixel(pack_yuyv(pick_sample(), pick_sample(),
                                          pick_sample(), pick_sample()));
            end
        end
    endtask

    task automatic run_output_holdoff();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_req   = 1'b1;
        repeat (32)
        begin
            send_macropixel($urandom());
        end
    endtask

    // output side ready with random stalls and the long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (rx_wait != 0)
        begin
            m_axis_tready <= 1'b0;
            rx_wait--;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            m_axis_tready <= 1'b0;
            rx_wait = HOLD_CYCLES - 1;
        end
        else if (rx_idle_en && $urandom_range(0, 99) < 25)
        begin
            m_axis_tready <= 1'b0;
            rx_wait = idle_len() - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            rgb_pairs_due.push_back(convert_macropixel(s_axis_tdata));
        end
    end

    always @(posedge clk)
    begin : check_output
        logic [47:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (rgb_pairs_due.size() == 0)
            begin
                $display("%0t: unexpected output transaction expected none actual %012h",
                         $time, m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = rgb_pairs_due.pop_front();
                for (int i = 0; i < 6; i++)
                begin
                    if (m_axis_tdata[i*8 +: 8] !== want[i*8 +: 8])
                    begin
                        $display("%0t: %s mismatch expected %0d actual %0d", $time,
                                 chan_names[i], want[i*8 +: 8], m_axis_tdata[i*8 +: 8]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed_cases();
        run_random_stream();
        run_output_holdoff();
        s_axis_tvalid <= 1'b0;
        while (rgb_pairs_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/yuyv_pkg.sv
hdl/yuyv_chroma.sv
hdl/yuyv_lane.sv
hdl/yuyv_to_rgb_converter_top.sv
sim/tb_yuyv_to_rgb_converter_top.sv
